// ===== sv/utc_to_local_time_eu_dst_assert.svh =====
// assertion macros for the utc to local time converter
`ifndef UTC_TO_LOCAL_TIME_EU_DST_ASSERT_SVH
`define UTC_TO_LOCAL_TIME_EU_DST_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UTCL_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("utcl assertion failed");
`define UTCL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("utcl assertion failed");
`else
`define UTCL_ASSERT(label, ante, cons)
`define UTCL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== sv/utcl_pkg.sv =====
// shared types, constants and calendar tables of the utc to local time converter
package utcl_pkg;

	localparam int DAY_SECS     = 86400;
	localparam int HOUR_SECS    = 3600;
	localparam int MIN_SECS     = 60;
	localparam int YEAR_DAYS    = 365;
	localparam int CENTURY_DAYS = 36525;

	// reciprocal multipliers, each estimate is off by at most one
	localparam int YEAR_RECIP = 2871;
	localparam int YEAR_SHIFT = 20;
	localparam int HOUR_RECIP = 1165;
	localparam int HOUR_SHIFT = 22;
	localparam int MIN_RECIP  = 1092;
	localparam int MIN_SHIFT  = 16;

	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_OCT = 4'd10;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZONE_OFFSET = 4'd0,
		CFG_DST_OFFSET  = 4'd1
	} cfg_idx_t;

	localparam logic signed [16:0] ZONE_RESET = 17'sd3600;
	localparam logic [12:0]        DST_RESET  = 13'd3600;

	typedef logic [15:0] day_t;
	typedef logic [16:0] sod_t;

	typedef struct packed {
		logic [6:0] year;
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} cal_t;

	localparam logic [8:0] CUM_DAYS [12] = '{
		9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	// last sunday day of month over the 28 year cycle, first entry is year 2000
	localparam logic [4:0] MAR_SUN [28] = '{
		5'd26, 5'd25, 5'd31, 5'd30, 5'd28, 5'd27, 5'd26,
		5'd25, 5'd30, 5'd29, 5'd28, 5'd27, 5'd25, 5'd31,
		5'd30, 5'd29, 5'd27, 5'd26, 5'd25, 5'd31, 5'd29,
		5'd28, 5'd27, 5'd26, 5'd31, 5'd30, 5'd29, 5'd28
	};

	localparam logic [4:0] OCT_SUN [28] = '{
		5'd29, 5'd28, 5'd27, 5'd26, 5'd31, 5'd30, 5'd29,
		5'd28, 5'd26, 5'd25, 5'd31, 5'd30, 5'd28, 5'd27,
		5'd26, 5'd25, 5'd30, 5'd29, 5'd28, 5'd27, 5'd25,
		5'd31, 5'd30, 5'd29, 5'd27, 5'd26, 5'd25, 5'd31
	};

endpackage

// ===== sv/utcl_if.sv =====
// channel interfaces of the utc to local time converter
interface utcl_utc_if;
	logic       valid;
	logic       ready;
	logic [5:0] utc_second;
	logic [5:0] utc_minute;
	logic [4:0] utc_hour;
	logic [4:0] utc_day;
	logic [3:0] utc_month;
	logic [6:0] utc_year;

	modport source (
		output valid, utc_second, utc_minute, utc_hour, utc_day, utc_month, utc_year,
		input  ready
	);
	modport sink (
		input  valid, utc_second, utc_minute, utc_hour, utc_day, utc_month, utc_year,
		output ready
	);
endinterface

interface utcl_local_if;
	logic       valid;
	logic       ready;
	logic [5:0] local_second;
	logic [5:0] local_minute;
	logic [4:0] local_hour;
	logic [4:0] local_day;
	logic [3:0] local_month;
	logic [6:0] local_year;
	logic       dst_active;

	modport source (
		output valid, local_second, local_minute, local_hour, local_day, local_month,
		       local_year, dst_active,
		input  ready
	);
	modport sink (
		input  valid, local_second, local_minute, local_hour, local_day, local_month,
		       local_year, dst_active,
		output ready
	);
endinterface

interface utcl_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [utcl_pkg::CFG_IDX_W-1:0]    index;
	logic [utcl_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/utcl_norm.sv =====
// input normalization: calendar fields to day index and second of day within the century
module utcl_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [5:0]          second,
	input  logic [5:0]          minute,
	input  logic [4:0]          hour,
	input  logic [4:0]          day,
	input  logic [3:0]          month,
	input  logic [6:0]          year,
	output logic                out_valid,
	output utcl_pkg::day_t      out_day_idx,
	output utcl_pkg::sod_t      out_sod
);

	logic [6:0]  y_mod;
	logic [6:0]  y_n;
	logic [3:0]  mi_n;
	logic [16:0] sod_raw;

	logic        valid_s1;
	logic [6:0]  y_s1;
	logic [3:0]  mi_s1;
	logic [4:0]  d_s1;
	logic [16:0] sod_s1;

	logic [16:0]        dsum;
	logic               leap_adj;
	logic signed [16:0] draw;

	logic               valid_s2;
	logic signed [16:0] draw_s2;
	logic [16:0]        sod_s2;

	logic               carry;
	logic [16:0]        sod_n;
	logic signed [16:0] dc;
	logic [15:0]        dn;

	logic           valid_s3;
	utcl_pkg::day_t day_s3;
	utcl_pkg::sod_t sod_s3;

	// month zero borrows from the previous year, months past december roll into the next
	always_comb begin
		y_mod = (year >= 7'd100) ? 7'(year - 7'd100) : year;
		if (month == 4'd0) begin
			mi_n = 4'd11;
			y_n  = (y_mod == 7'd0) ? 7'd99 : 7'(y_mod - 7'd1);
		end else if (month > 4'd12) begin
			mi_n = 4'(month - 4'd13);
			y_n  = (y_mod == 7'd99) ? 7'd0 : 7'(y_mod + 7'd1);
		end else begin
			mi_n = 4'(month - 4'd1);
			y_n  = y_mod;
		end
		sod_raw = 17'(17'(hour) * 17'(utcl_pkg::HOUR_SECS))
		        + 17'(17'(minute) * 17'(utcl_pkg::MIN_SECS))
		        + 17'(second);
	end

	always_comb begin
		leap_adj = (mi_s1 > 4'd1) && (y_s1[1:0] == 2'd0);
		dsum = 17'(17'(y_s1) * 17'(utcl_pkg::YEAR_DAYS))
		     + 17'((17'(y_s1) + 17'd3) >> 2)
		     + 17'(utcl_pkg::CUM_DAYS[mi_s1])
		     + 17'(leap_adj);
		// day zero lands on minus one here
		draw = $signed(17'(dsum + 17'(d_s1) - 17'd1));
	end

	always_comb begin
		carry = sod_s2 >= 17'(utcl_pkg::DAY_SECS);
		sod_n = carry ? 17'(sod_s2 - 17'(utcl_pkg::DAY_SECS)) : sod_s2;
		dc    = draw_s2 + $signed({16'd0, carry});
		if (dc[16]) begin
			dn = 16'(dc + 17'(utcl_pkg::CENTURY_DAYS));
		end else if (dc[15:0] >= 16'(utcl_pkg::CENTURY_DAYS)) begin
			dn = 16'(dc[15:0] - 16'(utcl_pkg::CENTURY_DAYS));
		end else begin
			dn = dc[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s1    <= y_n;
			mi_s1   <= mi_n;
			d_s1    <= day;
			sod_s1  <= sod_raw;
			draw_s2 <= draw;
			sod_s2  <= sod_s1;
			day_s3  <= dn;
			sod_s3  <= sod_n;
		end
	end

	assign out_valid   = valid_s3;
	assign out_day_idx = day_s3;
	assign out_sod     = sod_s3;

endmodule

// ===== sv/utcl_split.sv =====
// splits a day index and second of day into year, month, day, hour, minute and second
module utcl_split (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  utcl_pkg::day_t  day_idx,
	input  utcl_pkg::sod_t  sod,
	input  logic            flag,
	output logic            out_valid,
	output utcl_pkg::cal_t  out_cal,
	output utcl_pkg::day_t  out_day_idx,
	output utcl_pkg::sod_t  out_sod,
	output logic            out_flag
);

	// stage 1: reciprocal products
	logic           valid_s1;
	logic [27:0]    yprod_s1;
	logic [27:0]    hprod_s1;
	utcl_pkg::day_t day_s1;
	utcl_pkg::sod_t sod_s1;
	logic           flag_s1;

	// stage 2: year and hour estimates
	logic [6:0]     ye;
	logic [15:0]    start;
	logic [4:0]     hh_e;
	logic [12:0]    hrem;

	logic           valid_s2;
	logic [6:0]     ye_s2;
	logic [15:0]    start_s2;
	logic [4:0]     hh_s2;
	logic [12:0]    hrem_s2;
	utcl_pkg::day_t day_s2;
	utcl_pkg::sod_t sod_s2;
	logic           flag_s2;

	// stage 3: corrections
	logic           under;
	logic [6:0]     ye_m1;
	logic [15:0]    doy16;
	logic           hcarry;
	logic [11:0]    mrem;

	logic           valid_s3;
	logic [6:0]     year_s3;
	logic [8:0]     doy_s3;
	logic [4:0]     hh_s3;
	logic [11:0]    mrem_s3;
	utcl_pkg::day_t day_s3;
	utcl_pkg::sod_t sod_s3;
	logic           flag_s3;

	// stage 4: month search
	logic           leap;
	logic [8:0]     thr;
	logic [3:0]     mi;
	logic [8:0]     base;

	logic           valid_s4;
	logic [6:0]     year_s4;
	logic [8:0]     doy_s4;
	logic [3:0]     mi_s4;
	logic [8:0]     base_s4;
	logic [4:0]     hh_s4;
	logic [11:0]    mrem_s4;
	logic [22:0]    mprod_s4;
	utcl_pkg::day_t day_s4;
	utcl_pkg::sod_t sod_s4;
	logic           flag_s4;

	// stage 5: day of month, minute and second
	logic [5:0]     mm_e;
	logic [6:0]     srem;
	utcl_pkg::cal_t cal;

	logic           valid_s5;
	utcl_pkg::cal_t cal_s5;
	utcl_pkg::day_t day_s5;
	utcl_pkg::sod_t sod_s5;
	logic           flag_s5;

	always_comb begin
		ye    = 7'(yprod_s1 >> utcl_pkg::YEAR_SHIFT);
		start = 16'(16'(ye) * 16'(utcl_pkg::YEAR_DAYS)) + 16'((16'(ye) + 16'd3) >> 2);
		hh_e  = 5'(hprod_s1 >> utcl_pkg::HOUR_SHIFT);
		hrem  = 13'(sod_s1 - 17'(17'(hh_e) * 17'(utcl_pkg::HOUR_SECS)));
	end

	// the year estimate may run one high, the hour estimate one low
	always_comb begin
		under  = day_s2 < start_s2;
		ye_m1  = 7'(ye_s2 - 7'd1);
		doy16  = 16'(day_s2 - start_s2);
		if (under) begin
			doy16 = 16'(doy16 + ((ye_m1[1:0] == 2'd0) ? 16'd366 : 16'd365));
		end
		hcarry = hrem_s2 >= 13'(utcl_pkg::HOUR_SECS);
		mrem   = hcarry ? 12'(hrem_s2 - 13'(utcl_pkg::HOUR_SECS)) : 12'(hrem_s2);
	end

	always_comb begin
		leap = year_s3[1:0] == 2'd0;
		mi   = 4'd0;
		base = 9'd0;
		thr  = 9'd0;
		for (int k = 1; k < 12; k++) begin
			thr = utcl_pkg::CUM_DAYS[k] + 9'((k >= 2) && leap);
			if (doy_s3 >= thr) begin
				mi   = 4'(k);
				base = thr;
			end
		end
	end

	always_comb begin
		mm_e = 6'(mprod_s4 >> utcl_pkg::MIN_SHIFT);
		srem = 7'(mrem_s4 - 12'(12'(mm_e) * 12'(utcl_pkg::MIN_SECS)));
		cal.year  = year_s4;
		cal.month = 4'(mi_s4 + 4'd1);
		cal.day   = 5'(doy_s4 - base_s4 + 9'd1);
		cal.hour  = hh_s4;
		if (srem >= 7'(utcl_pkg::MIN_SECS)) begin
			cal.minute = 6'(mm_e + 6'd1);
			cal.second = 6'(srem - 7'(utcl_pkg::MIN_SECS));
		end else begin
			cal.minute = mm_e;
			cal.second = 6'(srem);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			yprod_s1 <= 28'(day_idx) * 28'(utcl_pkg::YEAR_RECIP);
			hprod_s1 <= 28'(sod) * 28'(utcl_pkg::HOUR_RECIP);
			day_s1   <= day_idx;
			sod_s1   <= sod;
			flag_s1  <= flag;

			ye_s2    <= ye;
			start_s2 <= start;
			hh_s2    <= hh_e;
			hrem_s2  <= hrem;
			day_s2   <= day_s1;
			sod_s2   <= sod_s1;
			flag_s2  <= flag_s1;

			year_s3  <= under ? ye_m1 : ye_s2;
			doy_s3   <= doy16[8:0];
			hh_s3    <= 5'(hh_s2 + 5'(hcarry));
			mrem_s3  <= mrem;
			day_s3   <= day_s2;
			sod_s3   <= sod_s2;
			flag_s3  <= flag_s2;

			year_s4  <= year_s3;
			doy_s4   <= doy_s3;
			mi_s4    <= mi;
			base_s4  <= base;
			hh_s4    <= hh_s3;
			mrem_s4  <= mrem_s3;
			mprod_s4 <= 23'(mrem_s3) * 23'(utcl_pkg::MIN_RECIP);
			day_s4   <= day_s3;
			sod_s4   <= sod_s3;
			flag_s4  <= flag_s3;

			cal_s5   <= cal;
			day_s5   <= day_s4;
			sod_s5   <= sod_s4;
			flag_s5  <= flag_s4;
		end
	end

	assign out_valid   = valid_s5;
	assign out_cal     = cal_s5;
	assign out_day_idx = day_s5;
	assign out_sod     = sod_s5;
	assign out_flag    = flag_s5;

endmodule

// ===== sv/utcl_dst.sv =====
// daylight saving window check and offset addition with day carry
module utcl_dst (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  utcl_pkg::cal_t     cal,
	input  utcl_pkg::day_t     day_idx,
	input  utcl_pkg::sod_t     sod,
	input  logic signed [16:0] zone_offset,
	input  logic [12:0]        dst_offset,
	output logic               out_valid,
	output utcl_pkg::day_t     out_day_idx,
	output utcl_pkg::sod_t     out_sod,
	output logic               out_dst
);

	logic [6:0] ycyc;
	logic [4:0] ycyc_idx;
	logic [4:0] mar_sun;
	logic [4:0] oct_sun;
	logic       after_mar;
	logic       before_oct;

	logic           valid_s1;
	logic           dst_s1;
	utcl_pkg::day_t day_s1;
	utcl_pkg::sod_t sod_s1;

	logic signed [18:0] offset;
	logic signed [18:0] sum;

	logic               valid_s2;
	logic               dst_s2;
	utcl_pkg::day_t     day_s2;
	logic signed [18:0] sum_s2;

	utcl_pkg::day_t day_n;
	utcl_pkg::sod_t sod_n;

	logic           valid_s3;
	logic           dst_s3;
	utcl_pkg::day_t day_s3;
	utcl_pkg::sod_t sod_s3;

	// weekdays repeat every 28 years inside the century
	always_comb begin
		if (cal.year >= 7'd84) begin
			ycyc = 7'(cal.year - 7'd84);
		end else if (cal.year >= 7'd56) begin
			ycyc = 7'(cal.year - 7'd56);
		end else if (cal.year >= 7'd28) begin
			ycyc = 7'(cal.year - 7'd28);
		end else begin
			ycyc = cal.year;
		end
		ycyc_idx = ycyc[4:0];
		mar_sun  = utcl_pkg::MAR_SUN[ycyc_idx];
		oct_sun  = utcl_pkg::OCT_SUN[ycyc_idx];

		// switch instants are 01:00:00 utc, both bounds exclusive
		after_mar = (cal.month > utcl_pkg::MONTH_MAR)
		         || ((cal.month == utcl_pkg::MONTH_MAR)
		             && ((cal.day > mar_sun)
		                 || ((cal.day == mar_sun) && (sod > 17'(utcl_pkg::HOUR_SECS)))));
		before_oct = (cal.month < utcl_pkg::MONTH_OCT)
		          || ((cal.month == utcl_pkg::MONTH_OCT)
		              && ((cal.day < oct_sun)
		                  || ((cal.day == oct_sun) && (sod < 17'(utcl_pkg::HOUR_SECS)))));
	end

	always_comb begin
		offset = 19'(zone_offset) + (dst_s1 ? $signed({6'd0, dst_offset}) : 19'sd0);
		sum    = $signed({2'b00, sod_s1}) + offset;
	end

	always_comb begin
		if (sum_s2[18]) begin
			sod_n = 17'(sum_s2 + 19'(utcl_pkg::DAY_SECS));
			day_n = (day_s2 == 16'd0) ? 16'(utcl_pkg::CENTURY_DAYS - 1) : 16'(day_s2 - 16'd1);
		end else if (sum_s2 >= 19'(utcl_pkg::DAY_SECS)) begin
			sod_n = 17'(sum_s2 - 19'(utcl_pkg::DAY_SECS));
			day_n = (day_s2 == 16'(utcl_pkg::CENTURY_DAYS - 1)) ? 16'd0 : 16'(day_s2 + 16'd1);
		end else begin
			sod_n = sum_s2[16:0];
			day_n = day_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_s1 <= after_mar && before_oct;
			day_s1 <= day_idx;
			sod_s1 <= sod;
			dst_s2 <= dst_s1;
			day_s2 <= day_s1;
			sum_s2 <= sum;
			dst_s3 <= dst_s2;
			day_s3 <= day_n;
			sod_s3 <= sod_n;
		end
	end

	assign out_valid   = valid_s3;
	assign out_day_idx = day_s3;
	assign out_sod     = sod_s3;
	assign out_dst     = dst_s3;

endmodule

// ===== sv/utc_to_local_time_eu_dst.sv =====
// UTC to local time converter with the EU daylight saving rule, years 2000 to 2099.
// Each word on utc is a UTC date and time; loc returns one word per input with the
// local date and time and a flag that tells whether the DST offset was applied.
// The datapath is a 16 stage pipeline (normalize 3, split 5, DST and offset 3,
// split 5) and takes one word every cycle unless a finished word waits at the output. The pipeline
// holds as a whole while the output word is not taken, so utc.ready follows
// loc.ready when a result is waiting. Register 0 on cfg is the signed zone offset in
// seconds (reset 3600), register 1 the DST offset in seconds (reset 3600); cfg.ready
// is always high and registers should be written only while the pipeline is empty.
`include "utc_to_local_time_eu_dst_assert.svh"

module utc_to_local_time_eu_dst (
	input  logic          clk,
	input  logic          arst_n,
	utcl_utc_if.sink      utc,
	utcl_local_if.source  loc,
	utcl_cfg_if.sink      cfg
);

	logic signed [16:0] zone_q;
	logic [12:0]        dst_off_q;

	logic en;

	logic           n_valid;
	utcl_pkg::day_t n_day;
	utcl_pkg::sod_t n_sod;

	logic           u_valid;
	utcl_pkg::cal_t u_cal;
	utcl_pkg::day_t u_day;
	utcl_pkg::sod_t u_sod;
	logic           u_flag;

	logic           d_valid;
	utcl_pkg::day_t d_day;
	utcl_pkg::sod_t d_sod;
	logic           d_dst;

	logic           l_valid;
	utcl_pkg::cal_t l_cal;
	utcl_pkg::day_t l_day;
	utcl_pkg::sod_t l_sod;
	logic           l_flag;

	// whole pipeline moves unless a finished word is stuck at the output
	assign en        = !l_valid || loc.ready;
	assign utc.ready = en;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q    <= utcl_pkg::ZONE_RESET;
			dst_off_q <= utcl_pkg::DST_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				utcl_pkg::CFG_ZONE_OFFSET: zone_q    <= $signed(cfg.data);
				utcl_pkg::CFG_DST_OFFSET:  dst_off_q <= cfg.data[12:0];
				default: ;
			endcase
		end
	end

	utcl_norm u_norm (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (utc.valid),
		.second      (utc.utc_second),
		.minute      (utc.utc_minute),
		.hour        (utc.utc_hour),
		.day         (utc.utc_day),
		.month       (utc.utc_month),
		.year        (utc.utc_year),
		.out_valid   (n_valid),
		.out_day_idx (n_day),
		.out_sod     (n_sod)
	);

	utcl_split u_split_utc (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (n_valid),
		.day_idx     (n_day),
		.sod         (n_sod),
		.flag        (1'b0),
		.out_valid   (u_valid),
		.out_cal     (u_cal),
		.out_day_idx (u_day),
		.out_sod     (u_sod),
		.out_flag    (u_flag)
	);

	utcl_dst u_dst (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (u_valid),
		.cal         (u_cal),
		.day_idx     (u_day),
		.sod         (u_sod),
		.zone_offset (zone_q),
		.dst_offset  (dst_off_q),
		.out_valid   (d_valid),
		.out_day_idx (d_day),
		.out_sod     (d_sod),
		.out_dst     (d_dst)
	);

	utcl_split u_split_local (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (d_valid),
		.day_idx     (d_day),
		.sod         (d_sod),
		.flag        (d_dst),
		.out_valid   (l_valid),
		.out_cal     (l_cal),
		.out_day_idx (l_day),
		.out_sod     (l_sod),
		.out_flag    (l_flag)
	);

	assign loc.valid        = l_valid;
	assign loc.local_second = l_cal.second;
	assign loc.local_minute = l_cal.minute;
	assign loc.local_hour   = l_cal.hour;
	assign loc.local_day    = l_cal.day;
	assign loc.local_month  = l_cal.month;
	assign loc.local_year   = l_cal.year;
	assign loc.dst_active   = l_flag;

	`UTCL_ASSERT(a_out_range, loc.valid, (loc.local_second < 6'd60) && (loc.local_minute < 6'd60) && (loc.local_hour < 5'd24) && (loc.local_day != 5'd0) && (loc.local_month != 4'd0) && (loc.local_month <= 4'd12) && (loc.local_year < 7'd100))
	`UTCL_ASSERT(a_dst_season, loc.valid && loc.dst_active, (loc.local_month >= utcl_pkg::MONTH_MAR) && (loc.local_month <= utcl_pkg::MONTH_OCT))
	`UTCL_ASSERT(a_feb_length, loc.valid && (loc.local_month == utcl_pkg::MONTH_FEB), loc.local_day <= 5'd29)
	`UTCL_ASSERT_NEXT(a_cfg_dst_write, cfg.valid && cfg.ready && (cfg.index == utcl_pkg::CFG_DST_OFFSET), dst_off_q == $past(cfg.data[12:0]))

endmodule

// ===== verif/utc_to_local_time_eu_dst_test.sv =====
// self-checking testbench of the utc to local time converter with eu daylight saving
`timescale 1ns / 1ps

module utc_to_local_time_eu_dst_test;

	localparam longint CENTURY_SECS = longint'(utcl_pkg::CENTURY_DAYS) * utcl_pkg::DAY_SECS;
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 170;
	localparam int NUM_PHASES = 7;
	localparam int NUM_FIXED = 5;
	localparam int NUM_DIRECTED = 21;
	localparam logic [utcl_pkg::CFG_IDX_W-1:0] UNUSED_CFG_IDX = 4'd9;

	localparam int CUM_DAYS_TB [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int MONTH_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	typedef struct packed {
		utcl_pkg::cal_t cal;
		logic           dst;
	} local_word_t;

	// fields of cal_t: year, month, day, hour, minute, second
	typedef struct packed {
		utcl_pkg::cal_t utc_time;
		logic           typed;
		utcl_pkg::cal_t local_time;
		logic           dst;
	} dir_row_t;

	typedef struct packed {
		logic signed [16:0] zone;
		logic [16:0]        dst;
		logic               quiet;
		logic               hold;
	} phase_t;

	localparam utcl_pkg::cal_t NO_CAL = '0;

	localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
		'{'{7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0}, 1'b1, '{7'd0, 4'd1, 5'd1, 5'd1, 6'd0, 6'd0}, 1'b0},
		'{'{7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b1,
			'{7'd0, 4'd1, 5'd1, 5'd0, 6'd59, 6'd59}, 1'b0},
		'{'{7'd0, 4'd7, 5'd1, 5'd12, 6'd0, 6'd0}, 1'b1, '{7'd0, 4'd7, 5'd1, 5'd14, 6'd0, 6'd0}, 1'b1},
		// march switch: exactly 01:00 is still standard time
		'{'{7'd0, 4'd3, 5'd26, 5'd1, 6'd0, 6'd0}, 1'b1, '{7'd0, 4'd3, 5'd26, 5'd2, 6'd0, 6'd0}, 1'b0},
		'{'{7'd0, 4'd3, 5'd26, 5'd1, 6'd0, 6'd1}, 1'b1, '{7'd0, 4'd3, 5'd26, 5'd3, 6'd0, 6'd1}, 1'b1},
		// october switch
		'{'{7'd0, 4'd10, 5'd29, 5'd0, 6'd59, 6'd59}, 1'b1,
			'{7'd0, 4'd10, 5'd29, 5'd2, 6'd59, 6'd59}, 1'b1},
		'{'{7'd0, 4'd10, 5'd29, 5'd1, 6'd0, 6'd0}, 1'b1,
			'{7'd0, 4'd10, 5'd29, 5'd2, 6'd0, 6'd0}, 1'b0},
		'{'{7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd1, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd4, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd5, 4'd0, 5'd15, 5'd10, 6'd30, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd99, 4'd13, 5'd5, 5'd0, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd20, 4'd14, 5'd10, 5'd0, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd30, 4'd15, 5'd31, 5'd0, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd110, 4'd6, 5'd15, 5'd8, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd10, 4'd4, 5'd31, 5'd23, 6'd59, 6'd59}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd10, 4'd5, 5'd10, 5'd31, 6'd63, 6'd63}, 1'b0, NO_CAL, 1'b0},
		// seconds overflow into the next year, dst window from the new year
		'{'{7'd9, 4'd12, 5'd31, 5'd23, 6'd59, 6'd63}, 1'b0, NO_CAL, 1'b0},
		'{'{7'd99, 4'd10, 5'd31, 5'd23, 6'd0, 6'd0}, 1'b0, NO_CAL, 1'b0}
	};

	localparam phase_t PHASES [NUM_FIXED] = '{
		'{-17'sd50400, 17'd0, 1'b0, 1'b1},
		'{17'sd50400, 17'd7200, 1'b0, 1'b0},
		'{17'sd0, 17'h1FFFF, 1'b1, 1'b0},
		'{17'sh10000, 17'd1, 1'b0, 1'b0},
		'{17'sh0FFFF, 17'd7200, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	utcl_utc_if   utc ();
	utcl_local_if loc ();
	utcl_cfg_if   cfg ();

	utc_to_local_time_eu_dst u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.utc    (utc),
		.loc    (loc),
		.cfg    (cfg)
	);

	local_word_t expected_locals [$];
	longint zone_secs;
	longint dst_secs;
	int     fail_count;
	int     idle_pct;
	bit     hold_req;
	int     cycle_count;

	function automatic bit leap_in_century(longint y);
		return (y % 4) == 0;
	endfunction

	function automatic longint month_days(longint y, int mi);
		return longint'(MONTH_LEN[mi] + ((mi == 1 && leap_in_century(y)) ? 1 : 0));
	endfunction

	// days since 2000-01-01
	function automatic longint day_count(longint y, int mi, longint d);
		longint n;
		n = y * 365 + (y + 3) / 4 + CUM_DAYS_TB[mi] + d;
		if (mi > 1 && leap_in_century(y))
			n += 1;
		return n;
	endfunction

	function automatic longint sunday_switch_secs(longint y, int mi);
		longint last;
		longint wd;
		last = day_count(y, mi, month_days(y, mi) - 1);
		wd = (last + 6) % 7;
		return (last - wd) * utcl_pkg::DAY_SECS + utcl_pkg::HOUR_SECS;
	endfunction

	function automatic utcl_pkg::cal_t split_century_secs(longint t);
		longint         days;
		longint         rem;
		longint         r;
		longint         yr;
		int             m;
		utcl_pkg::cal_t c;
		days = t / utcl_pkg::DAY_SECS;
		rem = t % utcl_pkg::DAY_SECS;
		r = days % 1461;
		yr = (days / 1461) * 4;
		if (r >= 366) begin
			yr += 1 + (r - 366) / 365;
			r = (r - 366) % 365;
		end
		m = 0;
		while (m < 11 && r >= month_days(yr, m)) begin
			r -= month_days(yr, m);
			m++;
		end
		c.year = 7'(yr);
		c.month = 4'(m + 1);
		c.day = 5'(r + 1);
		c.hour = 5'(rem / 3600);
		c.minute = 6'((rem % 3600) / 60);
		c.second = 6'(rem % 60);
		return c;
	endfunction

	function automatic local_word_t convert_to_local(utcl_pkg::cal_t u);
		longint         yr;
		longint         mo;
		longint         t;
		longint         dd;
		longint         hh;
		longint         mm;
		longint         ss;
		int             mi;
		utcl_pkg::cal_t norm;
		local_word_t    w;
		yr = u.year;
		yr = yr % 100;
		mo = u.month;
		dd = u.day;
		hh = u.hour;
		mm = u.minute;
		ss = u.second;
		if (mo == 0) begin
			mi = 11;
			yr = (yr + 99) % 100;
		end else if (mo > 12) begin
			mi = int'(mo - 13);
			yr = (yr + 1) % 100;
		end else begin
			mi = int'(mo - 1);
		end
		t = day_count(yr, mi, dd - 1) * utcl_pkg::DAY_SECS + hh * 3600 + mm * 60 + ss;
		t = ((t % CENTURY_SECS) + CENTURY_SECS) % CENTURY_SECS;
		norm = split_century_secs(t);
		w.dst = (t > sunday_switch_secs(norm.year, 2)) && (t < sunday_switch_secs(norm.year, 9));
		t = t + zone_secs + (w.dst ? dst_secs : 0);
		t = ((t % CENTURY_SECS) + CENTURY_SECS) % CENTURY_SECS;
		w.cal = split_century_secs(t);
		return w;
	endfunction

	task automatic send_time(input utcl_pkg::cal_t u, input bit typed,
			input local_word_t typed_word);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			utc.valid <= 1'b0;
			@(negedge clk);
		end
		utc.valid <= 1'b1;
		utc.utc_year <= u.year;
		utc.utc_month <= u.month;
		utc.utc_day <= u.day;
		utc.utc_hour <= u.hour;
		utc.utc_minute <= u.minute;
		utc.utc_second <= u.second;
		@(posedge clk);
		while (!utc.ready)
			@(posedge clk);
		expected_locals.push_back(typed ? typed_word : convert_to_local(u));
	endtask

	task automatic wait_drained();
		@(negedge clk);
		utc.valid <= 1'b0;
		while (expected_locals.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [utcl_pkg::CFG_IDX_W-1:0] idx,
			input logic [utcl_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			utcl_pkg::CFG_ZONE_OFFSET: zone_secs = $signed(value);
			utcl_pkg::CFG_DST_OFFSET:  dst_secs = value[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		loc.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				loc.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			loc.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	always @(posedge clk) begin : check_local
		local_word_t want;
		if (arst_n && loc.valid && loc.ready) begin
			if (expected_locals.size() == 0) begin
				$error("local time word with none expected");
				fail_count++;
			end else begin
				want = expected_locals.pop_front();
				check_field("local_second", want.cal.second, loc.local_second);
				check_field("local_minute", want.cal.minute, loc.local_minute);
				check_field("local_hour", want.cal.hour, loc.local_hour);
				check_field("local_day", want.cal.day, loc.local_day);
				check_field("local_month", want.cal.month, loc.local_month);
				check_field("local_year", want.cal.year, loc.local_year);
				check_field("dst_active", want.dst, loc.dst_active);
			end
		end
	end

	initial begin
		utcl_pkg::cal_t stim;
		local_word_t    typed_word;
		phase_t         ph;
		int             sel;
		int             yr;
		int             mo;
		arst_n = 1'b0;
		utc.valid = 1'b0;
		utc.utc_second = '0;
		utc.utc_minute = '0;
		utc.utc_hour = '0;
		utc.utc_day = '0;
		utc.utc_month = '0;
		utc.utc_year = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		idle_pct = 24;
		hold_req = 1'b0;
		fail_count = 0;
		zone_secs = utcl_pkg::ZONE_RESET;
		dst_secs = utcl_pkg::DST_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED[i]) begin
			typed_word.cal = DIRECTED[i].local_time;
			typed_word.dst = DIRECTED[i].dst;
			send_time(DIRECTED[i].utc_time, DIRECTED[i].typed, typed_word);
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p < NUM_FIXED) begin
				ph = PHASES[p];
			end else begin
				ph.zone = 17'(int'($urandom_range(100800)) - 50400);
				ph.dst = 17'($urandom_range(7200));
				ph.quiet = 1'b0;
				ph.hold = 1'b0;
			end
			wait_drained();
			write_reg(utcl_pkg::CFG_ZONE_OFFSET, ph.zone);
			write_reg(utcl_pkg::CFG_DST_OFFSET, ph.dst);
			// unmapped index must leave both registers alone
			if (p == 2)
				write_reg(UNUSED_CFG_IDX, '1);
			idle_pct = ph.quiet ? 0 : 24;
			if (ph.hold)
				hold_req = 1'b1;
			repeat (PHASE_ITEMS) begin
				sel = int'($urandom_range(99));
				if (sel < 15) begin
					// raw bits, out-of-range fields included
					stim.year = 7'($urandom_range(127));
					stim.month = 4'($urandom_range(15));
					stim.day = 5'($urandom_range(31));
					stim.hour = 5'($urandom_range(31));
					stim.minute = 6'($urandom_range(63));
					stim.second = 6'($urandom_range(63));
				end else if (sel < 45) begin
					// around the last sunday 01:00 switch points
					stim.year = 7'($urandom_range(99));
					stim.month = $urandom_range(1) ? utcl_pkg::MONTH_MAR : utcl_pkg::MONTH_OCT;
					stim.day = 5'($urandom_range(25, 31));
					stim.hour = 5'($urandom_range(2));
					case ($urandom_range(3))
						0: stim.minute = 6'd0;
						1: stim.minute = 6'd59;
						default: stim.minute = 6'($urandom_range(59));
					endcase
					case ($urandom_range(3))
						0: stim.second = 6'd0;
						1: stim.second = 6'd1;
						2: stim.second = 6'd59;
						default: stim.second = 6'($urandom_range(59));
					endcase
				end else begin
					yr = int'($urandom_range(99));
					mo = int'($urandom_range(1, 12));
					stim.year = 7'(yr);
					stim.month = 4'(mo);
					stim.day = 5'($urandom_range(1, int'(month_days(yr, mo - 1))));
					stim.hour = 5'($urandom_range(23));
					stim.minute = 6'($urandom_range(59));
					stim.second = 6'($urandom_range(59));
				end
				send_time(stim, 1'b0, typed_word);
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/utcl_pkg.sv
sv/utcl_if.sv
sv/utcl_norm.sv
sv/utcl_split.sv
sv/utcl_dst.sv
sv/utc_to_local_time_eu_dst.sv
verif/utc_to_local_time_eu_dst_test.sv
